// ===== hdl/lstr_pkg.sv =====
`timescale 1ns / 1ps

package lstr_pkg;

   // clamps on the configured geometry
   localparam int unsigned MAX_LEN    = 256;
   localparam int unsigned MAX_BORDER = 64;

   // field widths
   localparam int unsigned LED_W    = 10;
   localparam int unsigned LEN_W    = 9;
   localparam int unsigned BORD_W   = 7;
   localparam int unsigned COLOR_W  = 8;
   localparam int unsigned TRAIL_W  = 6;
   localparam int unsigned SECTOR_W = 10;
   localparam int unsigned CANVAS_W = 9;
   localparam int unsigned PATH_W   = 10;
   localparam int unsigned INDEX_W  = 11;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LED_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAIL        = 3'd6;

   // floor(255/t) and 255 mod t, used to step ceil(255*k/t) without a divider
   localparam logic [7:0] STEP_QUOT [64] = '{
      8'd0,   8'd255, 8'd127, 8'd85,  8'd63,  8'd51,  8'd42,  8'd36,
      8'd31,  8'd28,  8'd25,  8'd23,  8'd21,  8'd19,  8'd18,  8'd17,
      8'd15,  8'd15,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,  8'd11,
      8'd10,  8'd10,  8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,
      8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd6,   8'd6,   8'd6,
      8'd6,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd5,   8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4
   };
   localparam logic [TRAIL_W-1:0] STEP_REM [64] = '{
      6'd0,  6'd0,  6'd1,  6'd0,  6'd3,  6'd0,  6'd3,  6'd3,
      6'd7,  6'd3,  6'd5,  6'd2,  6'd3,  6'd8,  6'd3,  6'd0,
      6'd15, 6'd0,  6'd3,  6'd8,  6'd15, 6'd3,  6'd13, 6'd2,
      6'd15, 6'd5,  6'd21, 6'd12, 6'd3,  6'd23, 6'd15, 6'd7,
      6'd31, 6'd24, 6'd17, 6'd10, 6'd3,  6'd33, 6'd27, 6'd21,
      6'd15, 6'd9,  6'd3,  6'd40, 6'd35, 6'd30, 6'd25, 6'd20,
      6'd15, 6'd10, 6'd5,  6'd0,  6'd47, 6'd43, 6'd39, 6'd35,
      6'd31, 6'd27, 6'd23, 6'd19, 6'd15, 6'd11, 6'd7,  6'd3
   };

   // configuration as seen by the datapath (geometry already clamped)
   typedef struct packed {
      logic [LED_W-1:0]    led_start;
      logic [BORD_W-1:0]   bord;
      logic [CANVAS_W-1:0] canvas;
      logic [PATH_W-1:0]   path;
      logic [COLOR_W-1:0]  red;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  blue;
      logic [TRAIL_W-1:0]  trail;
   } cfg_type;

   // one pixel write leaving the sequencer
   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic [PATH_W-1:0]   slot;
      logic [COLOR_W-1:0]  bright;
   } pix_type;

endpackage

// ===== hdl/lstr_csr.sv =====
`timescale 1ns / 1ps

module lstr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lstr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lstr_pkg::CSR_DATA_W-1:0] csr_data,
   output lstr_pkg::cfg_type               cfg
);
   import lstr_pkg::*;

   logic [LED_W-1:0]    led_start_ff;
   logic [LEN_W-1:0]    strip_length_ff;
   logic [BORD_W-1:0]   border_ff;
   logic [COLOR_W-1:0]  red_ff, green_ff, blue_ff;
   logic [TRAIL_W-1:0]  trail_ff;

   logic [LEN_W-1:0]    len_in;
   logic [BORD_W-1:0]   bord_in, bord_ff;
   logic [CANVAS_W-1:0] canvas_in, canvas_ff;
   logic [PATH_W-1:0]   path_in, path_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_start_ff    <= '0;
         strip_length_ff <= LEN_W'(16);
         border_ff       <= '0;
         red_ff          <= '1;
         green_ff        <= '1;
         blue_ff         <= '1;
         trail_ff        <= TRAIL_W'(5);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LED_START:    led_start_ff    <= csr_data[LED_W-1:0];
            CSR_STRIP_LENGTH: strip_length_ff <= csr_data[LEN_W-1:0];
            CSR_BORDER:       border_ff       <= csr_data[BORD_W-1:0];
            CSR_RED:          red_ff          <= csr_data[COLOR_W-1:0];
            CSR_GREEN:        green_ff        <= csr_data[COLOR_W-1:0];
            CSR_BLUE:         blue_ff         <= csr_data[COLOR_W-1:0];
            CSR_TRAIL:        trail_ff        <= csr_data[TRAIL_W-1:0];
            default: ;
         endcase
      end
   end

   // geometry is registered once more, behind the config registers, before the sequencer reads it
   always_comb begin
      if (strip_length_ff == '0) begin
         len_in = LEN_W'(1);
      end else if (strip_length_ff > LEN_W'(MAX_LEN)) begin
         len_in = LEN_W'(MAX_LEN);
      end else begin
         len_in = strip_length_ff;
      end
      bord_in   = (border_ff > BORD_W'(MAX_BORDER)) ? BORD_W'(MAX_BORDER) : border_ff;
      canvas_in = CANVAS_W'(len_in) + CANVAS_W'({bord_in, 1'b0});
      path_in   = (canvas_in > CANVAS_W'(1))
                  ? ({canvas_in, 1'b0} - PATH_W'(2))
                  : PATH_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bord_ff   <= '0;
         canvas_ff <= CANVAS_W'(16);
         path_ff   <= PATH_W'(30);
      end else begin
         bord_ff   <= bord_in;
         canvas_ff <= canvas_in;
         path_ff   <= path_in;
      end
   end

   always_comb begin
      cfg.led_start = led_start_ff;
      cfg.bord      = bord_ff;
      cfg.canvas    = canvas_ff;
      cfg.path      = path_ff;
      cfg.red       = red_ff;
      cfg.green     = green_ff;
      cfg.blue      = blue_ff;
      cfg.trail     = trail_ff;
   end

endmodule

// ===== hdl/lstr_seq.sv =====
`timescale 1ns / 1ps

module lstr_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  lstr_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lstr_pkg::SECTOR_W-1:0] sector,
   input  logic                          adv,
   output lstr_pkg::pix_type             pix
);
   import lstr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PREP = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [SECTOR_W-1:0]  pos_ff, pos_in;
   logic [PATH_W-1:0]    slot_ff, slot_in;
   logic [7:0]           q_ff, q_in;
   logic [TRAIL_W-1:0]   rem_ff, rem_in;
   logic [TRAIL_W-1:0]   k_ff, k_in;

   logic                 is_last;
   logic [TRAIL_W:0]     rem_sum;
   logic                 wrap;

   assign req_tready = (state_ff == ST_IDLE);
   assign is_last    = (k_ff == cfg.trail);

   assign rem_sum = {1'b0, rem_ff} + {1'b0, STEP_REM[cfg.trail]};
   assign wrap    = (rem_sum >= {1'b0, cfg.trail});

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      slot_in  = slot_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pos_in   = sector;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // position past the path saturates to its last slot
            slot_in  = (PATH_W'(pos_ff) >= cfg.path) ? (cfg.path - PATH_W'(1))
                                                      : PATH_W'(pos_ff);
            q_in     = '0;
            rem_in   = cfg.trail - TRAIL_W'(1);
            k_in     = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (adv) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in    = k_ff + TRAIL_W'(1);
                  slot_in = (slot_ff == '0) ? (cfg.path - PATH_W'(1))
                                            : (slot_ff - PATH_W'(1));
                  q_in    = q_ff + STEP_QUOT[cfg.trail] + 8'(wrap);
                  rem_in  = wrap ? TRAIL_W'(rem_sum - {1'b0, cfg.trail})
                                 : rem_sum[TRAIL_W-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      slot_ff <= slot_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
   end

   always_comb begin
      pix.valid  = (state_ff == ST_RUN);
      pix.first  = (k_ff == '0);
      pix.last   = is_last;
      pix.slot   = slot_ff;
      pix.bright = (cfg.trail == '0) ? 8'd255 : (8'd255 - q_ff);
   end

endmodule

// ===== hdl/lstr_shade.sv =====
`timescale 1ns / 1ps

module lstr_shade (
   input  logic                          clock,
   input  logic                          reset,
   input  lstr_pkg::cfg_type             cfg,
   input  lstr_pkg::pix_type             pix,
   output logic                          adv,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          clear_first,
   output logic                          visible,
   output logic [lstr_pkg::INDEX_W-1:0]  led_index,
   output logic [lstr_pkg::COLOR_W-1:0]  red_out,
   output logic [lstr_pkg::COLOR_W-1:0]  green_out,
   output logic [lstr_pkg::COLOR_W-1:0]  blue_out,
   output logic                          last
);
   import lstr_pkg::*;

   // exact floor(x/255) for x up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   // stage 1: fold path slot onto the canvas
   logic                 v1_ff, first1_ff, last1_ff;
   logic [CANVAS_W-1:0]  c1_ff, c1_in;
   logic [COLOR_W-1:0]   br1_ff;

   // stage 2: visibility, LED number, colour products
   logic                 v2_ff, first2_ff, last2_ff, vis2_ff, vis2_in;
   logic [INDEX_W-1:0]   led2_ff, led2_in;
   logic [15:0]          pr2_ff, pg2_ff, pb2_ff;

   // stage 3: output register
   logic                 v3_ff, first3_ff, last3_ff, vis3_ff;
   logic [INDEX_W-1:0]   led3_ff;
   logic [COLOR_W-1:0]   r3_ff, g3_ff, b3_ff;

   assign adv = !v3_ff || rsp_tready;

   assign c1_in = (pix.slot < PATH_W'(cfg.canvas)) ? pix.slot[CANVAS_W-1:0]
                                                   : CANVAS_W'(cfg.path - pix.slot);

   assign vis2_in = (c1_ff >= CANVAS_W'(cfg.bord))
                 && (c1_ff < (cfg.canvas - CANVAS_W'(cfg.bord)));
   assign led2_in = INDEX_W'(cfg.led_start) + INDEX_W'(c1_ff) - INDEX_W'(cfg.bord);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= pix.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         first1_ff <= pix.first;
         last1_ff  <= pix.last;
         c1_ff     <= c1_in;
         br1_ff    <= pix.bright;

         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         vis2_ff   <= vis2_in;
         led2_ff   <= led2_in;
         pr2_ff    <= 16'(br1_ff) * 16'(cfg.red);
         pg2_ff    <= 16'(br1_ff) * 16'(cfg.green);
         pb2_ff    <= 16'(br1_ff) * 16'(cfg.blue);

         first3_ff <= first2_ff;
         last3_ff  <= last2_ff;
         vis3_ff   <= vis2_ff;
         led3_ff   <= vis2_ff ? led2_ff : '0;
         r3_ff     <= vis2_ff ? div255(pr2_ff) : '0;
         g3_ff     <= vis2_ff ? div255(pg2_ff) : '0;
         b3_ff     <= vis2_ff ? div255(pb2_ff) : '0;
      end
   end

   assign rsp_tvalid  = v3_ff;
   assign clear_first = first3_ff;
   assign visible     = vis3_ff;
   assign led_index   = led3_ff;
   assign red_out     = r3_ff;
   assign green_out   = g3_ff;
   assign blue_out    = b3_ff;
   assign last        = last3_ff;

endmodule

// ===== hdl/led_sweep_trail_renderer.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                   payload
// req       in   req_tvalid / req_tready     req_tdata[9:0] sector
// rsp       out  rsp_tvalid / rsp_tready     rsp_tdata led/r/g/b, rsp_tuser, rsp_tlast
// csr       in   csr_valid / csr_ready       csr_index, csr_data
//
// One sector at a time at the input: accept, a prep state to clamp the position, then
// one pixel write per cycle from the sequencer unless rsp stalls (trail + 1 writes).
// Writes reach rsp three register stages after the sequencer (fold, multiply, scale).
// reset is synchronous, active high; registers come back to their documented values.
// A stall on rsp freezes the whole pipeline and a running sweep; csr is always ready.
module led_sweep_trail_renderer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // [9:0] sector, rest zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [10:0] led_index, [18:11] red_out, [26:19] green_out, [34:27] blue_out, rest zero
   output logic [39:0]                     rsp_tdata,
   output logic [1:0]                      rsp_tuser,   // [0] clear_first, [1] visible
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lstr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lstr_pkg::CSR_DATA_W-1:0] csr_data
);
   import lstr_pkg::*;

   cfg_type             cfg;
   pix_type             pix;
   logic                adv;
   logic                clear_first, visible;
   logic [INDEX_W-1:0]  led_index;
   logic [COLOR_W-1:0]  red_out, green_out, blue_out;

   lstr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lstr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sector     (req_tdata[SECTOR_W-1:0]),
      .adv        (adv),
      .pix        (pix)
   );

   lstr_shade u_shade (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pix         (pix),
      .adv         (adv),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .clear_first (clear_first),
      .visible     (visible),
      .led_index   (led_index),
      .red_out     (red_out),
      .green_out   (green_out),
      .blue_out    (blue_out),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, blue_out, green_out, red_out, led_index};
   assign rsp_tuser = {visible, clear_first};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lstr_pkg::*;

   // index with no register behind it; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic               clear_first;
      logic               visible;
      logic [INDEX_W-1:0] led_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last;
   } sweep_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // shadow copy of the register file
   logic [LED_W-1:0]   cfg_led_start;
   logic [LEN_W-1:0]   cfg_strip_length;
   logic [BORD_W-1:0]  cfg_border;
   logic [COLOR_W-1:0] cfg_red;
   logic [COLOR_W-1:0] cfg_green;
   logic [COLOR_W-1:0] cfg_blue;
   logic [TRAIL_W-1:0] cfg_trail;

   sweep_pixel_type expected_pixels[$];
   int unsigned  mismatches = 0;
   int unsigned  rsp_gap = 0;
   int unsigned  rx_hold = 0;
   bit           steady = 1'b0;

   led_sweep_trail_renderer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("led_sweep_trail_renderer regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns  %s: got %0d, expected %0d", $time, field, got, want);
      mismatches++;
   endtask

   // clamped geometry of the current configuration
   function automatic void sweep_geometry(output int unsigned bord,
                                          output int unsigned canvas,
                                          output int unsigned path);
      int unsigned len;
      len = cfg_strip_length;
      if (len < 1) len = 1;
      if (len > MAX_LEN) len = MAX_LEN;
      bord = cfg_border;
      if (bord > MAX_BORDER) bord = MAX_BORDER;
      canvas = len + 2 * bord;
      path = (canvas > 1) ? 2 * canvas - 2 : 1;
   endfunction

   // queue up the trail of pixel writes for one sweep position
   function automatic void render_sweep(input logic [SECTOR_W-1:0] sector);
      int unsigned  bord, canvas, path, pos, slot, c, bright, t, k;
      sweep_pixel_type px;
      sweep_geometry(bord, canvas, path);
      t = cfg_trail;
      pos = sector;
      if (pos >= path) pos = path - 1;
      for (k = 0; k <= t; k++) begin
         slot = (pos + path * 64 - k) % path;
         c = (slot < canvas) ? slot : 2 * canvas - 2 - slot;
         bright = (t == 0) ? 255 : 255 - (255 * k + t - 1) / t;
         px = '0;
         px.clear_first = (k == 0);
         px.visible = (c >= bord) && (c < canvas - bord);
         if (px.visible) begin
            px.led_index = INDEX_W'(cfg_led_start + c - bord);
            px.red = COLOR_W'((bright * cfg_red) / 255);
            px.green = COLOR_W'((bright * cfg_green) / 255);
            px.blue = COLOR_W'((bright * cfg_blue) / 255);
         end
         px.last = (k == t);
         expected_pixels.push_back(px);
      end
   endfunction

   // all tasks below start and end on a falling edge
   task automatic send_sector(input logic [SECTOR_W-1:0] sector);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(16 - SECTOR_W){1'b0}}, sector};
      do @(posedge clock); while (!req_tready);
      render_sweep(sector);
      @(negedge clock);
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // block idle: all writes drained plus pipeline depth
   task automatic wait_idle();
      wait_results();
      repeat (8) @(negedge clock);
   endtask

   task automatic cfg_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LED_START:    cfg_led_start = LED_W'(value);
         CSR_STRIP_LENGTH: cfg_strip_length = LEN_W'(value);
         CSR_BORDER:       cfg_border = BORD_W'(value);
         CSR_RED:          cfg_red = COLOR_W'(value);
         CSR_GREEN:        cfg_green = COLOR_W'(value);
         CSR_BLUE:         cfg_blue = COLOR_W'(value);
         CSR_TRAIL:        cfg_trail = TRAIL_W'(value);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_config(input int unsigned start, input int unsigned len,
                              input int unsigned bord, input int unsigned r,
                              input int unsigned g, input int unsigned b,
                              input int unsigned t);
      wait_idle();
      cfg_write(CSR_LED_START, start);
      cfg_write(CSR_STRIP_LENGTH, len);
      cfg_write(CSR_BORDER, bord);
      cfg_write(CSR_RED, r);
      cfg_write(CSR_GREEN, g);
      cfg_write(CSR_BLUE, b);
      cfg_write(CSR_TRAIL, t);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SECTOR_W-1:0] pick_sector();
      int unsigned bord, canvas, path;
      sweep_geometry(bord, canvas, path);
      if ($urandom_range(0, 7) == 0) return SECTOR_W'($urandom_range(0, 1023));
      return SECTOR_W'($urandom_range(0, path - 1));
   endfunction

   // reset values: 16 LEDs, no border, white, trail of 5
   task automatic test_reset_defaults();
      send_sector(0);      // trail wraps behind path start
      send_sector(1);
      send_sector(15);     // far end of the strip
      send_sector(29);     // last path slot
      send_sector(30);     // beyond path, saturates
      send_sector(1023);
   endtask

   task automatic test_full_canvas();
      load_config(1023, 256, 64, 255, 0, 128, 63);
      send_sector(0);
      send_sector(64);
      send_sector(319);
      send_sector(765);
      send_sector(766);
      send_sector(1023);
   endtask

   // length 0 clamps to 1: single-slot canvas, zero trail
   task automatic test_single_slot();
      load_config(0, 0, 0, 1, 254, 127, 0);
      send_sector(0);
      send_sector(1023);
   endtask

   task automatic test_clamped_geometry();
      load_config(512, 511, 127, 170, 85, 255, 1);
      send_sector(10);
      send_sector(700);
   endtask

   // three-slot canvas, long trail wraps the path many times
   task automatic test_short_path();
      load_config(5, 1, 1, 255, 255, 255, 63);
      send_sector(0);
      send_sector(3);
   endtask

   task automatic test_spare_register();
      wait_idle();
      cfg_write(CSR_SPARE, 10'h3ff);
      csr_valid <= 1'b0;
      @(negedge clock);
      send_sector(2);
      send_sector(1);
   endtask

   // receiver holds off while the sender keeps pushing
   task automatic test_backpressure();
      load_config(100, 16, 2, 200, 100, 50, 7);
      rx_hold = 300;
      steady = 1'b1;
      repeat (16) send_sector(pick_sector());
      steady = 1'b0;
      wait_results();
   endtask

   task automatic test_random();
      int unsigned phase, n;
      for (phase = 0; phase < 6; phase++) begin
         load_config($urandom_range(0, 1023),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(1, 40),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 4),
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), $urandom_range(0, 1023));
         if (phase % 2 == 1) begin
            cfg_write(CSR_SPARE, $urandom_range(0, 1023));
            csr_valid <= 1'b0;
            @(negedge clock);
         end
         for (n = 0; n < 14; n++) begin
            steady = (n < 5);
            if (n == 10 && phase == 2) wait_results();
            send_sector(pick_sector());
         end
         steady = 1'b0;
      end
   endtask

   // result side: ready with random hold-offs
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold--;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sweep_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_gap = steady ? 0 : $urandom_range(0, 7);
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected transaction, led_index", rsp_tdata[10:0], 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tuser[0] !== want.clear_first)
               report_mismatch("clear_first", rsp_tuser[0], want.clear_first);
            if (rsp_tuser[1] !== want.visible)
               report_mismatch("visible", rsp_tuser[1], want.visible);
            if (rsp_tdata[10:0] !== want.led_index)
               report_mismatch("led_index", rsp_tdata[10:0], want.led_index);
            if (rsp_tdata[18:11] !== want.red)
               report_mismatch("red_out", rsp_tdata[18:11], want.red);
            if (rsp_tdata[26:19] !== want.green)
               report_mismatch("green_out", rsp_tdata[26:19], want.green);
            if (rsp_tdata[34:27] !== want.blue)
               report_mismatch("blue_out", rsp_tdata[34:27], want.blue);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_led_start = 0;
      cfg_strip_length = 16;
      cfg_border = 0;
      cfg_red = 255;
      cfg_green = 255;
      cfg_blue = 255;
      cfg_trail = 5;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_full_canvas();
      test_single_slot();
      test_clamped_geometry();
      test_short_path();
      test_spare_register();
      test_backpressure();
      test_random();

      wait_idle();
      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("led_sweep_trail_renderer regression: pass");
      else
         $display("led_sweep_trail_renderer regression: fail");
      $finish;
   end

endmodule
